/* src/ubx_fp_pkg.sv */
// ----------------------------------------------------------------------------
// ubx_fp_pkg
// Shared constants and types of the UBX frame parser with end-of-epoch gate.
// ----------------------------------------------------------------------------
package ubx_fp_pkg;

	localparam int unsigned MAX_PAYLOAD = 256;
	localparam logic [31:0] AGE_RESET   = 32'd150000;

	localparam logic [1:0] ST_NONE     = 2'd0;
	localparam logic [1:0] ST_GOOD     = 2'd1;
	localparam logic [1:0] ST_CKSUM    = 2'd2;
	localparam logic [1:0] ST_OVERSIZE = 2'd3;

	localparam logic [2:0] KIND_OTHER = 3'd0;
	localparam logic [2:0] KIND_PVT   = 3'd1;
	localparam logic [2:0] KIND_DOP   = 3'd2;
	localparam logic [2:0] KIND_COV   = 3'd3;
	localparam logic [2:0] KIND_EOE   = 3'd4;

	localparam logic [7:0]  CLS_NAV = 8'h01;
	localparam logic [7:0]  ID_PVT  = 8'h07;
	localparam logic [7:0]  ID_DOP  = 8'h04;
	localparam logic [7:0]  ID_COV  = 8'h36;
	localparam logic [7:0]  ID_EOE  = 8'h61;
	localparam logic [15:0] LEN_PVT = 16'd92;
	localparam logic [15:0] LEN_DOP = 16'd18;
	localparam logic [15:0] LEN_COV = 16'd64;
	localparam logic [15:0] LEN_EOE = 16'd4;

	typedef struct packed {
		logic        payload_valid;
		logic [7:0]  payload_byte;
		logic [7:0]  payload_index;
		logic [1:0]  frame_status;
		logic [7:0]  msg_class;
		logic [7:0]  msg_id;
		logic [15:0] msg_length;
	} frame_res_t;

	typedef struct packed {
		logic        good;
		logic [7:0]  cls;
		logic [7:0]  id;
		logic [15:0] len;
		logic [31:0] first_word;
	} frame_info_t;

endpackage

/* src/ubx_fp_framer.sv */
// ----------------------------------------------------------------------------
// ubx_fp_framer
// Byte-level frame state machine: sync search, header capture, length check,
// Fletcher sums, payload streaming and checksum verdict.
// ----------------------------------------------------------------------------
module ubx_fp_framer #(
	parameter int unsigned MAX_PAYLOAD = ubx_fp_pkg::MAX_PAYLOAD
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  logic [7:0]             rx_byte,
	output ubx_fp_pkg::frame_res_t res,
	output ubx_fp_pkg::frame_info_t info
);

	localparam logic [3:0] PH_SYNC1   = 4'd0;
	localparam logic [3:0] PH_SYNC2   = 4'd1;
	localparam logic [3:0] PH_CLASS   = 4'd2;
	localparam logic [3:0] PH_ID      = 4'd3;
	localparam logic [3:0] PH_LENL    = 4'd4;
	localparam logic [3:0] PH_LENH    = 4'd5;
	localparam logic [3:0] PH_PAYLOAD = 4'd6;
	localparam logic [3:0] PH_CKA     = 4'd7;
	localparam logic [3:0] PH_CKB     = 4'd8;

	localparam logic [7:0]  SYNC_A  = 8'hB5;
	localparam logic [7:0]  SYNC_B  = 8'h62;
	localparam logic [16:0] MAX_LEN = 17'(MAX_PAYLOAD);

	logic [3:0]  phase_q, phase_n;
	logic [7:0]  cls_q, cls_n;
	logic [7:0]  id_q, id_n;
	logic [15:0] len_q, len_n;
	logic [15:0] cnt_q, cnt_n;
	logic [7:0]  sa_q, sa_n;
	logic [7:0]  sb_q, sb_n;
	logic [31:0] fw_q, fw_n;
	logic [7:0]  sa_add, sb_add;
	logic [15:0] cnt_inc;

	assign sa_add  = sa_q + rx_byte;
	assign sb_add  = sb_q + sa_add;
	assign cnt_inc = cnt_q + 16'd1;

	always_comb begin
		phase_n = phase_q;
		cls_n   = cls_q;
		id_n    = id_q;
		len_n   = len_q;
		cnt_n   = cnt_q;
		sa_n    = sa_q;
		sb_n    = sb_q;
		fw_n    = fw_q;
		res.payload_valid = 1'b0;
		res.payload_byte  = 8'd0;
		res.payload_index = 8'd0;
		res.frame_status  = ubx_fp_pkg::ST_NONE;
		info.good = 1'b0;
		case (phase_q)
			PH_SYNC2: begin
				if (rx_byte == SYNC_B) begin
					phase_n = PH_CLASS;
				end else if (rx_byte != SYNC_A) begin
					phase_n = PH_SYNC1;
				end
			end
			PH_CLASS: begin
				cls_n   = rx_byte;
				sa_n    = rx_byte;
				sb_n    = rx_byte;
				fw_n    = 32'd0;
				phase_n = PH_ID;
			end
			PH_ID: begin
				id_n    = rx_byte;
				sa_n    = sa_add;
				sb_n    = sb_add;
				phase_n = PH_LENL;
			end
			PH_LENL: begin
				len_n   = {8'd0, rx_byte};
				sa_n    = sa_add;
				sb_n    = sb_add;
				phase_n = PH_LENH;
			end
			PH_LENH: begin
				len_n = {rx_byte, len_q[7:0]};
				sa_n  = sa_add;
				sb_n  = sb_add;
				cnt_n = 16'd0;
				if ({1'b0, len_n} > MAX_LEN) begin
					res.frame_status = ubx_fp_pkg::ST_OVERSIZE;
					phase_n = PH_SYNC1;
				end else if (len_n == 16'd0) begin
					phase_n = PH_CKA;
				end else begin
					phase_n = PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				res.payload_valid = 1'b1;
				res.payload_byte  = rx_byte;
				res.payload_index = cnt_q[7:0];
				if (cnt_q < 16'd4) begin
					case (cnt_q[1:0])
						2'd0:    fw_n[7:0]   = rx_byte;
						2'd1:    fw_n[15:8]  = rx_byte;
						2'd2:    fw_n[23:16] = rx_byte;
						default: fw_n[31:24] = rx_byte;
					endcase
				end
				sa_n  = sa_add;
				sb_n  = sb_add;
				cnt_n = cnt_inc;
				if (cnt_inc >= len_q) begin
					phase_n = PH_CKA;
				end
			end
			PH_CKA: begin
				if (rx_byte == sa_q) begin
					phase_n = PH_CKB;
				end else begin
					res.frame_status = ubx_fp_pkg::ST_CKSUM;
					phase_n = PH_SYNC1;
				end
			end
			PH_CKB: begin
				phase_n = PH_SYNC1;
				if (rx_byte != sb_q) begin
					res.frame_status = ubx_fp_pkg::ST_CKSUM;
				end else begin
					res.frame_status = ubx_fp_pkg::ST_GOOD;
					info.good = 1'b1;
				end
			end
			default: begin
				phase_n = (rx_byte == SYNC_A) ? PH_SYNC2 : PH_SYNC1;
			end
		endcase
		res.msg_class  = cls_n;
		res.msg_id     = id_n;
		res.msg_length = len_n;
		info.cls        = cls_q;
		info.id         = id_q;
		info.len        = len_q;
		info.first_word = fw_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SYNC1;
			cls_q   <= 8'd0;
			id_q    <= 8'd0;
			len_q   <= 16'd0;
			cnt_q   <= 16'd0;
			sa_q    <= 8'd0;
			sb_q    <= 8'd0;
			fw_q    <= 32'd0;
		end else if (step) begin
			phase_q <= phase_n;
			cls_q   <= cls_n;
			id_q    <= id_n;
			len_q   <= len_n;
			cnt_q   <= cnt_n;
			sa_q    <= sa_n;
			sb_q    <= sb_n;
			fw_q    <= fw_n;
		end
	end

`ifndef SYNTHESIS
	a_good_from_ckb: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.frame_status == ubx_fp_pkg::ST_GOOD |-> phase_q == PH_CKB)
		else $error("Good frame reported outside the second checksum byte.");

	a_payload_clean: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.payload_valid |->
			phase_q == PH_PAYLOAD && res.frame_status == ubx_fp_pkg::ST_NONE)
		else $error("Payload beat outside the payload phase.");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		step && phase_q == PH_PAYLOAD |=> cnt_q <= len_q)
		else $error("Payload count ran past the declared length.");
`endif

endmodule

/* src/ubx_fp_epoch.sv */
// ----------------------------------------------------------------------------
// ubx_fp_epoch
// Classifies good NAV frames and gates the end of epoch on a fresh PVT with
// matching iTOW.
// ----------------------------------------------------------------------------
module ubx_fp_epoch (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    step,
	input  logic [63:0]             now,
	input  logic [31:0]             max_age,
	input  ubx_fp_pkg::frame_info_t info,
	output logic [2:0]              kind,
	output logic                    publish
);

	logic [31:0] itow_q;
	logic [63:0] pvt_time_q;
	logic        armed_q;
	logic        dop_q;
	logic        cov_q;
	logic [63:0] age;
	logic        fresh;

	assign age   = now - pvt_time_q;
	assign fresh = age < {32'd0, max_age};

	always_comb begin
		kind = ubx_fp_pkg::KIND_OTHER;
		if (info.good && info.cls == ubx_fp_pkg::CLS_NAV) begin
			if (info.id == ubx_fp_pkg::ID_PVT && info.len == ubx_fp_pkg::LEN_PVT) begin
				kind = ubx_fp_pkg::KIND_PVT;
			end else if (info.id == ubx_fp_pkg::ID_DOP && info.len == ubx_fp_pkg::LEN_DOP) begin
				kind = ubx_fp_pkg::KIND_DOP;
			end else if (info.id == ubx_fp_pkg::ID_COV && info.len == ubx_fp_pkg::LEN_COV) begin
				kind = ubx_fp_pkg::KIND_COV;
			end else if (info.id == ubx_fp_pkg::ID_EOE && info.len == ubx_fp_pkg::LEN_EOE) begin
				kind = ubx_fp_pkg::KIND_EOE;
			end
		end
		publish = (kind == ubx_fp_pkg::KIND_EOE) && armed_q
			&& (info.first_word == itow_q) && fresh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			itow_q     <= 32'd0;
			pvt_time_q <= 64'd0;
			armed_q    <= 1'b0;
			dop_q      <= 1'b0;
			cov_q      <= 1'b0;
		end else if (step) begin
			case (kind)
				ubx_fp_pkg::KIND_PVT: begin
					armed_q    <= 1'b1;
					itow_q     <= info.first_word;
					pvt_time_q <= now;
				end
				ubx_fp_pkg::KIND_DOP: begin
					dop_q <= 1'b1;
				end
				ubx_fp_pkg::KIND_COV: begin
					cov_q <= 1'b1;
				end
				ubx_fp_pkg::KIND_EOE: begin
					armed_q <= 1'b0;
					dop_q   <= 1'b0;
					cov_q   <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_publish_eoe: assert property (@(posedge clk) disable iff (!arst_n)
		step && publish |-> kind == ubx_fp_pkg::KIND_EOE && armed_q)
		else $error("Epoch published without an armed end of epoch.");

	a_eoe_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step && kind == ubx_fp_pkg::KIND_EOE |=> !armed_q && !dop_q && !cov_q)
		else $error("End of epoch left the gate state set.");

	a_pvt_arms: assert property (@(posedge clk) disable iff (!arst_n)
		step && kind == ubx_fp_pkg::KIND_PVT |=> armed_q && pvt_time_q == $past(now))
		else $error("PVT did not arm the gate with its arrival time.");
`endif

endmodule

/* src/ubx_frame_parser_epoch_gate.sv */
// ----------------------------------------------------------------------------
// ubx_frame_parser_epoch_gate
// UBX frame parser with Fletcher checksum and end-of-epoch publish gate.
// ----------------------------------------------------------------------------
// Each received byte gives one result beat. A byte is captured in an input
// register and parsed combinationally into a result register. A new byte can
// be taken every cycle while out_ready holds, so the sustained rate is one
// byte per clock unless the result side stalls. The slowest path is the
// 64-bit age subtraction and compare of the epoch gate. Payload bytes are
// streamed out as they arrive; downstream commits them when frame_status
// reports a good frame. The age limit register is written through the cfg
// channel, which is always ready, and must only be written while idle.
module ubx_frame_parser_epoch_gate #(
	parameter int unsigned MAX_PAYLOAD = ubx_fp_pkg::MAX_PAYLOAD
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	input  logic [63:0] rx_time_us,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        payload_valid,
	output logic [7:0]  payload_byte,
	output logic [7:0]  payload_index,
	output logic [1:0]  frame_status,
	output logic [2:0]  msg_kind,
	output logic [7:0]  msg_class,
	output logic [7:0]  msg_id,
	output logic [15:0] msg_length,
	output logic        epoch_publish
);

	logic [31:0] max_age_q;
	logic        v_s1;
	logic [7:0]  byte_s1;
	logic [63:0] time_s1;
	logic        v_s2;
	logic        adv;

	ubx_fp_pkg::frame_res_t  fr_res;
	ubx_fp_pkg::frame_info_t fr_info;
	ubx_fp_pkg::frame_res_t  res_s2;
	logic [2:0]              kind;
	logic                    publish;
	logic [2:0]              kind_s2;
	logic                    publish_s2;

	assign cfg_ready = 1'b1;
	assign adv       = v_s1 && (!v_s2 || out_ready);
	assign in_ready  = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_age_q <= ubx_fp_pkg::AGE_RESET;
		end else if (cfg_valid) begin
			max_age_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				v_s1 <= in_valid;
			end
			if (adv) begin
				v_s2 <= 1'b1;
			end else if (out_ready) begin
				v_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
			time_s1 <= rx_time_us;
		end
		if (adv) begin
			res_s2     <= fr_res;
			kind_s2    <= kind;
			publish_s2 <= publish;
		end
	end

	ubx_fp_framer #(
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_framer (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (adv),
		.rx_byte (byte_s1),
		.res     (fr_res),
		.info    (fr_info)
	);

	ubx_fp_epoch u_epoch (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (adv),
		.now     (time_s1),
		.max_age (max_age_q),
		.info    (fr_info),
		.kind    (kind),
		.publish (publish)
	);

	assign out_valid     = v_s2;
	assign payload_valid = res_s2.payload_valid;
	assign payload_byte  = res_s2.payload_byte;
	assign payload_index = res_s2.payload_index;
	assign frame_status  = res_s2.frame_status;
	assign msg_kind      = kind_s2;
	assign msg_class     = res_s2.msg_class;
	assign msg_id        = res_s2.msg_id;
	assign msg_length    = res_s2.msg_length;
	assign epoch_publish = publish_s2;

endmodule

/* tb/sv/ubx_parse_monitor.sv */
// ----------------------------------------------------------------------------
// ubx_parse_monitor
// Watches the parser's channels, predicts every result beat and compares.
// ----------------------------------------------------------------------------
// Each accepted input byte is run through a cycle-free model of the frame
// parser and its epoch gate, and the predicted result is queued. Each accepted
// result beat is compared with the oldest prediction. Writes on the
// configuration channel update the model's age limit. Counts are handed to
// the testbench top for the verdict and the run summary.
// ----------------------------------------------------------------------------
package ubx_tb_pkg;

	localparam logic [7:0] SYNC_A = 8'hB5;
	localparam logic [7:0] SYNC_B = 8'h62;

endpackage

module ubx_parse_monitor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  rx_byte,
	input  logic [63:0] rx_time_us,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic        payload_valid,
	input  logic [7:0]  payload_byte,
	input  logic [7:0]  payload_index,
	input  logic [1:0]  frame_status,
	input  logic [2:0]  msg_kind,
	input  logic [7:0]  msg_class,
	input  logic [7:0]  msg_id,
	input  logic [15:0] msg_length,
	input  logic        epoch_publish,
	output int unsigned mismatches,
	output int unsigned pending,
	output int unsigned beats_checked,
	output int unsigned good_frames,
	output int unsigned cksum_fails,
	output int unsigned oversize_frames,
	output int unsigned epochs_published
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [3:0] {
		WAIT_SYNC1,
		WAIT_SYNC2,
		GET_CLASS,
		GET_ID,
		GET_LEN_LO,
		GET_LEN_HI,
		GET_PAYLOAD,
		GET_CK_A,
		GET_CK_B
	} parse_phase_e;

	typedef struct packed {
		logic        payload_valid;
		logic [7:0]  payload_byte;
		logic [7:0]  payload_index;
		logic [1:0]  frame_status;
		logic [2:0]  msg_kind;
		logic [7:0]  msg_class;
		logic [7:0]  msg_id;
		logic [15:0] msg_length;
		logic        epoch_publish;
	} parse_result_t;

	parse_result_t predicted_beats[$];

	parse_phase_e phase;
	logic [7:0]   frame_class;
	logic [7:0]   frame_id;
	logic [15:0]  frame_len;
	logic [15:0]  payload_count;
	logic [7:0]   sum_a;
	logic [7:0]   sum_b;
	logic [31:0]  first_word;
	logic [31:0]  pvt_itow;
	logic [63:0]  pvt_time;
	logic         epoch_armed;
	logic [31:0]  max_age;

	int unsigned fail_count;
	int unsigned beat_count;
	int unsigned good_count;
	int unsigned cksum_count;
	int unsigned oversize_count;
	int unsigned publish_count;

	function automatic void add_to_sums(input logic [7:0] b);
		sum_a = sum_a + b;
		sum_b = sum_b + sum_a;
	endfunction

	function automatic parse_result_t parse_byte(input logic [7:0] b,
			input logic [63:0] now);
		parse_result_t r;
		r = '0;
		case (phase)
			WAIT_SYNC2: begin
				if (b == ubx_tb_pkg::SYNC_B)
					phase = GET_CLASS;
				else if (b != ubx_tb_pkg::SYNC_A)
					phase = WAIT_SYNC1;
			end
			GET_CLASS: begin
				frame_class = b;
				sum_a = '0;
				sum_b = '0;
				first_word = '0;
				add_to_sums(b);
				phase = GET_ID;
			end
			GET_ID: begin
				frame_id = b;
				add_to_sums(b);
				phase = GET_LEN_LO;
			end
			GET_LEN_LO: begin
				frame_len = {8'h00, b};
				add_to_sums(b);
				phase = GET_LEN_HI;
			end
			GET_LEN_HI: begin
				frame_len[15:8] = b;
				add_to_sums(b);
				payload_count = '0;
				if (frame_len > ubx_fp_pkg::MAX_PAYLOAD) begin
					r.frame_status = ubx_fp_pkg::ST_OVERSIZE;
					phase = WAIT_SYNC1;
				end else if (frame_len == 16'd0) begin
					phase = GET_CK_A;
				end else begin
					phase = GET_PAYLOAD;
				end
			end
			GET_PAYLOAD: begin
				r.payload_valid = 1'b1;
				r.payload_byte = b;
				r.payload_index = payload_count[7:0];
				if (payload_count < 16'd4)
					first_word[payload_count[1:0]*8 +: 8] = b;
				add_to_sums(b);
				payload_count = payload_count + 16'd1;
				if (payload_count >= frame_len)
					phase = GET_CK_A;
			end
			GET_CK_A: begin
				if (b == sum_a) begin
					phase = GET_CK_B;
				end else begin
					r.frame_status = ubx_fp_pkg::ST_CKSUM;
					phase = WAIT_SYNC1;
				end
			end
			GET_CK_B: begin
				phase = WAIT_SYNC1;
				if (b != sum_b) begin
					r.frame_status = ubx_fp_pkg::ST_CKSUM;
				end else begin
					r.frame_status = ubx_fp_pkg::ST_GOOD;
					r.msg_kind = ubx_fp_pkg::KIND_OTHER;
					if (frame_class == ubx_fp_pkg::CLS_NAV) begin
						if (frame_id == ubx_fp_pkg::ID_PVT
								&& frame_len == ubx_fp_pkg::LEN_PVT) begin
							epoch_armed = 1'b1;
							pvt_itow = first_word;
							pvt_time = now;
							r.msg_kind = ubx_fp_pkg::KIND_PVT;
						end else if (frame_id == ubx_fp_pkg::ID_DOP
								&& frame_len == ubx_fp_pkg::LEN_DOP) begin
							r.msg_kind = ubx_fp_pkg::KIND_DOP;
						end else if (frame_id == ubx_fp_pkg::ID_COV
								&& frame_len == ubx_fp_pkg::LEN_COV) begin
							r.msg_kind = ubx_fp_pkg::KIND_COV;
						end else if (frame_id == ubx_fp_pkg::ID_EOE
								&& frame_len == ubx_fp_pkg::LEN_EOE) begin
							r.epoch_publish = epoch_armed && first_word == pvt_itow &&
								(now - pvt_time) < {32'h0, max_age};
							epoch_armed = 1'b0;
							r.msg_kind = ubx_fp_pkg::KIND_EOE;
						end
					end
				end
			end
			default: begin
				phase = (b == ubx_tb_pkg::SYNC_A) ? WAIT_SYNC2 : WAIT_SYNC1;
			end
		endcase
		r.msg_class = frame_class;
		r.msg_id = frame_id;
		r.msg_length = frame_len;
		return r;
	endfunction

	function automatic string describe(input parse_result_t r);
		return $sformatf({"pv=%0d byte=%02h idx=%0d status=%0d kind=%0d",
			" class=%02h id=%02h len=%0d pub=%0d"},
			r.payload_valid, r.payload_byte, r.payload_index, r.frame_status, r.msg_kind,
			r.msg_class, r.msg_id, r.msg_length, r.epoch_publish);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		parse_result_t got;
		parse_result_t want;
		if (!arst_n) begin
			phase = WAIT_SYNC1;
			frame_class = '0;
			frame_id = '0;
			frame_len = '0;
			payload_count = '0;
			sum_a = '0;
			sum_b = '0;
			first_word = '0;
			pvt_itow = '0;
			pvt_time = '0;
			epoch_armed = 1'b0;
			max_age = ubx_fp_pkg::AGE_RESET;
			predicted_beats.delete();
			fail_count = 0;
			beat_count = 0;
			good_count = 0;
			cksum_count = 0;
			oversize_count = 0;
			publish_count = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				max_age = cfg_data;
			if (in_valid && in_ready)
				predicted_beats.push_back(parse_byte(rx_byte, rx_time_us));
			if (out_valid && out_ready) begin
				got = {payload_valid, payload_byte, payload_index, frame_status, msg_kind,
					msg_class, msg_id, msg_length, epoch_publish};
				if (predicted_beats.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: result beat with none predicted: %s", $realtime,
							describe(got));
				end else begin
					want = predicted_beats.pop_front();
					beat_count++;
					if (want.frame_status == ubx_fp_pkg::ST_GOOD)
						good_count++;
					if (want.frame_status == ubx_fp_pkg::ST_CKSUM)
						cksum_count++;
					if (want.frame_status == ubx_fp_pkg::ST_OVERSIZE)
						oversize_count++;
					if (want.epoch_publish)
						publish_count++;
					if (got !== want) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("%0t: mismatch on result beat %0d", $realtime, beat_count);
							$display("  expected %s", describe(want));
							$display("  actual   %s", describe(got));
						end
					end
				end
			end
		end
		mismatches <= fail_count;
		pending <= predicted_beats.size();
		beats_checked <= beat_count;
		good_frames <= good_count;
		cksum_fails <= cksum_count;
		oversize_frames <= oversize_count;
		epochs_published <= publish_count;
	end

endmodule

/* tb/sv/tb_ubx_frame_parser_epoch_gate.sv */
// ----------------------------------------------------------------------------
// tb_ubx_frame_parser_epoch_gate
// Stimulus and verdict for the UBX frame parser with end-of-epoch gate.
// ----------------------------------------------------------------------------
// A short directed sequence covers oversize and zero lengths, both checksum
// faults, repeated sync bytes, the longest payload and the age limit on both
// sides of its boundary, once across a wrap of the time counter. Random phases
// follow, each with its own age limit and time step, built mostly from
// well-formed NAV epochs and short frames with some corruption and noise. The
// sender works in bursts and the receiver stalls in changing patterns,
// including one long hold-off; the monitor beside the block does all checking.
// ----------------------------------------------------------------------------
module tb_ubx_frame_parser_epoch_gate;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned HOLD_CYCLES  = 80;
	localparam int unsigned PHASE_BUDGET = 16;

	typedef enum logic [1:0] {FAULT_NONE, FAULT_CK_A, FAULT_CK_B} frame_fault_e;
	typedef enum logic [1:0] {RX_ALWAYS, RX_MOSTLY, RX_PERIODIC, RX_SPARSE} rx_pace_e;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [31:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  rx_byte = '0;
	logic [63:0] rx_time_us = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        payload_valid;
	logic [7:0]  payload_byte;
	logic [7:0]  payload_index;
	logic [1:0]  frame_status;
	logic [2:0]  msg_kind;
	logic [7:0]  msg_class;
	logic [7:0]  msg_id;
	logic [15:0] msg_length;
	logic        epoch_publish;

	int unsigned mismatches;
	int unsigned pending;
	int unsigned beats_checked;
	int unsigned good_frames;
	int unsigned cksum_fails;
	int unsigned oversize_frames;
	int unsigned epochs_published;

	logic [63:0] now_us = '0;
	int unsigned step_max = 0;
	int unsigned burst_left = 0;
	int unsigned bytes_sent = 0;
	logic        steady = 1'b0;
	logic        hold_req = 1'b0;

	ubx_frame_parser_epoch_gate dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.rx_time_us(rx_time_us),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.payload_valid(payload_valid),
		.payload_byte(payload_byte),
		.payload_index(payload_index),
		.frame_status(frame_status),
		.msg_kind(msg_kind),
		.msg_class(msg_class),
		.msg_id(msg_id),
		.msg_length(msg_length),
		.epoch_publish(epoch_publish)
	);

	ubx_parse_monitor parse_mon (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.rx_time_us(rx_time_us),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.payload_valid(payload_valid),
		.payload_byte(payload_byte),
		.payload_index(payload_index),
		.frame_status(frame_status),
		.msg_kind(msg_kind),
		.msg_class(msg_class),
		.msg_id(msg_id),
		.msg_length(msg_length),
		.epoch_publish(epoch_publish),
		.mismatches(mismatches),
		.pending(pending),
		.beats_checked(beats_checked),
		.good_frames(good_frames),
		.cksum_fails(cksum_fails),
		.oversize_frames(oversize_frames),
		.epochs_published(epochs_published)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#10ms;
		$display("Verification failed");
		$finish;
	end

	// Receiver pacing, with a long hold-off whenever the stimulus asks for one.
	initial begin
		rx_pace_e    pace;
		int unsigned pace_left;
		int unsigned cyc;
		int unsigned held;
		pace = RX_ALWAYS;
		pace_left = 0;
		cyc = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			cyc++;
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				held = 0;
				while (held < HOLD_CYCLES) begin
					@(posedge clk);
					held++;
				end
			end
			if (pace_left == 0) begin
				pace = rx_pace_e'($urandom_range(0, 3));
				pace_left = $urandom_range(20, 200);
			end
			pace_left--;
			case (pace)
				RX_ALWAYS:   out_ready <= 1'b1;
				RX_MOSTLY:   out_ready <= ($urandom_range(0, 9) < 7);
				RX_PERIODIC: out_ready <= ((cyc % 5) < 3);
				default:     out_ready <= ($urandom_range(0, 9) < 3);
			endcase
		end
	end

	task automatic send_byte(input logic [7:0] value);
		int unsigned gap;
		if (!steady && burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		if (burst_left != 0)
			burst_left--;
		in_valid <= 1'b1;
		rx_byte <= value;
		rx_time_us <= now_us;
		do @(posedge clk); while (!in_ready);
		now_us = now_us + $urandom_range(0, step_max);
		bytes_sent++;
	endtask

	task automatic send_frame(input logic [7:0] cls, input logic [7:0] id,
			input logic [15:0] len, input logic [31:0] itow, input frame_fault_e fault,
			input int unsigned extra_sync);
		logic [7:0]  body[$];
		logic [7:0]  ck_a;
		logic [7:0]  ck_b;
		int unsigned i;
		body = {cls, id, len[7:0], len[15:8]};
		if (len <= ubx_fp_pkg::MAX_PAYLOAD) begin
			for (i = 0; i < len; i++)
				body.push_back((i < 4) ? itow[i*8 +: 8] : 8'($urandom));
		end
		ck_a = '0;
		ck_b = '0;
		foreach (body[k]) begin
			ck_a = ck_a + body[k];
			ck_b = ck_b + ck_a;
		end
		repeat (extra_sync) send_byte(ubx_tb_pkg::SYNC_A);
		send_byte(ubx_tb_pkg::SYNC_A);
		send_byte(ubx_tb_pkg::SYNC_B);
		foreach (body[k])
			send_byte(body[k]);
		if (len > ubx_fp_pkg::MAX_PAYLOAD)
			return;
		if (fault == FAULT_CK_A) begin
			send_byte(ck_a ^ 8'($urandom_range(1, 255)));
		end else begin
			send_byte(ck_a);
			send_byte((fault == FAULT_CK_B) ? (ck_b ^ 8'($urandom_range(1, 255))) : ck_b);
		end
	endtask

	function automatic frame_fault_e pick_fault();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 85)
			return FAULT_NONE;
		return (r < 92) ? FAULT_CK_A : FAULT_CK_B;
	endfunction

	function automatic int unsigned extra_sync();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 0;
	endfunction

	task automatic wait_all_done();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_max_age(input logic [31:0] value);
		wait_all_done();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_epoch();
		logic [31:0] itow;
		logic [31:0] eoe_itow;
		itow = $urandom;
		send_frame(ubx_fp_pkg::CLS_NAV, ubx_fp_pkg::ID_PVT, ubx_fp_pkg::LEN_PVT, itow,
			pick_fault(), extra_sync());
		if ($urandom_range(0, 3) == 0)
			send_frame(ubx_fp_pkg::CLS_NAV, ubx_fp_pkg::ID_DOP, ubx_fp_pkg::LEN_DOP,
				$urandom, pick_fault(), extra_sync());
		if ($urandom_range(0, 3) == 0)
			send_frame(ubx_fp_pkg::CLS_NAV, ubx_fp_pkg::ID_COV, ubx_fp_pkg::LEN_COV,
				$urandom, pick_fault(), extra_sync());
		eoe_itow = ($urandom_range(0, 4) == 0) ? (itow ^ (32'h1 << $urandom_range(0, 31)))
			: itow;
		send_frame(ubx_fp_pkg::CLS_NAV, ubx_fp_pkg::ID_EOE, ubx_fp_pkg::LEN_EOE, eoe_itow,
			pick_fault(), extra_sync());
	endtask

	task automatic run_random_phase(input int unsigned budget);
		int unsigned start;
		int unsigned pick;
		logic [7:0]  cls;
		logic [7:0]  id;
		start = bytes_sent;
		while (bytes_sent - start < budget) begin
			steady = ($urandom_range(0, 6) == 0);
			pick = $urandom_range(0, 99);
			if (pick < 25) begin
				send_epoch();
			end else if (pick < 40) begin
				send_frame(ubx_fp_pkg::CLS_NAV, ubx_fp_pkg::ID_EOE, ubx_fp_pkg::LEN_EOE,
					$urandom, pick_fault(), extra_sync());
			end else if (pick < 52) begin
				if ($urandom_range(0, 1))
					send_frame(ubx_fp_pkg::CLS_NAV, ubx_fp_pkg::ID_DOP, ubx_fp_pkg::LEN_DOP,
						$urandom, pick_fault(), extra_sync());
				else
					send_frame(ubx_fp_pkg::CLS_NAV, ubx_fp_pkg::ID_COV, ubx_fp_pkg::LEN_COV,
						$urandom, pick_fault(), extra_sync());
			end else if (pick < 76) begin
				cls = $urandom_range(0, 1) ? ubx_fp_pkg::CLS_NAV : 8'($urandom);
				case ($urandom_range(0, 4))
					0: id = ubx_fp_pkg::ID_PVT;
					1: id = ubx_fp_pkg::ID_DOP;
					2: id = ubx_fp_pkg::ID_COV;
					3: id = ubx_fp_pkg::ID_EOE;
					default: id = 8'($urandom);
				endcase
				send_frame(cls, id, 16'($urandom_range(0, 12)), $urandom, pick_fault(),
					extra_sync());
			end else if (pick < 84) begin
				send_frame(8'($urandom), 8'($urandom),
					16'($urandom_range(ubx_fp_pkg::MAX_PAYLOAD + 1, 65535)), '0, FAULT_NONE,
					extra_sync());
			end else if (pick < 94) begin
				repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
			end else begin
				now_us = {$urandom, $urandom};
			end
		end
		steady = 1'b0;
	endtask

	initial begin
		logic [31:0] age_limits[4];
		int unsigned step_limits[4];
		logic [63:0] t0;
		logic [63:0] age_full;
		age_limits = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'($urandom_range(1000, 400000))};
		step_limits = '{3, 200, 0, 50000};
		age_full = {32'd0, ubx_fp_pkg::AGE_RESET};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		step_max = 0;
		send_byte(8'h00);
		send_byte(8'hFF);
		send_frame(8'hFF, 8'hFF, 16'd0, '0, FAULT_NONE, 2);
		send_frame(8'h00, 8'h00, 16'(ubx_fp_pkg::MAX_PAYLOAD + 1), '0, FAULT_NONE, 0);
		send_frame(8'h5A, 8'hA5, 16'hFFFF, '0, FAULT_NONE, 0);
		send_frame(8'h02, 8'h13, 16'd2, 32'h0000_A55A, FAULT_CK_A, 0);
		send_frame(8'h02, 8'h13, 16'd2, 32'h0000_5AA5, FAULT_CK_B, 0);
		send_frame(8'hC3, 8'h3C, 16'(ubx_fp_pkg::MAX_PAYLOAD), $urandom, FAULT_NONE, 0);

		// One short of the limit, measured across a wrap of the time counter.
		now_us = 64'hFFFF_FFFF_FFFF_FFF0;
		send_frame(ubx_fp_pkg::CLS_NAV, ubx_fp_pkg::ID_PVT, ubx_fp_pkg::LEN_PVT,
			32'hDEAD_BEEF, FAULT_NONE, 0);
		now_us = age_full - 64'd17;
		send_frame(ubx_fp_pkg::CLS_NAV, ubx_fp_pkg::ID_EOE, ubx_fp_pkg::LEN_EOE,
			32'hDEAD_BEEF, FAULT_NONE, 0);
		send_frame(ubx_fp_pkg::CLS_NAV, ubx_fp_pkg::ID_EOE, ubx_fp_pkg::LEN_EOE,
			32'hDEAD_BEEF, FAULT_NONE, 0);

		// Exactly at the limit.
		t0 = 64'h0000_0001_0000_0000;
		now_us = t0;
		send_frame(ubx_fp_pkg::CLS_NAV, ubx_fp_pkg::ID_PVT, ubx_fp_pkg::LEN_PVT,
			32'h1234_5678, FAULT_NONE, 0);
		now_us = t0 + age_full;
		send_frame(ubx_fp_pkg::CLS_NAV, ubx_fp_pkg::ID_EOE, ubx_fp_pkg::LEN_EOE,
			32'h1234_5678, FAULT_NONE, 0);

		for (int p = 0; p < 4; p++) begin
			write_max_age(age_limits[p]);
			step_max = step_limits[p];
			now_us = {$urandom, $urandom};
			if (p == 1) begin
				// Hold the result side off while a whole frame is offered.
				hold_req = 1'b1;
				steady = 1'b1;
				send_frame(ubx_fp_pkg::CLS_NAV, ubx_fp_pkg::ID_DOP, ubx_fp_pkg::LEN_DOP,
					$urandom, FAULT_NONE, 0);
				steady = 1'b0;
			end
			run_random_phase(PHASE_BUDGET);
		end

		wait_all_done();
		repeat (10) @(posedge clk);
		$display("Run fed %0d bytes under the reset age limit and 4 written ones;",
			bytes_sent);
		$display("%0d beats checked: %0d good, %0d bad checksum, %0d oversize, %0d published.",
			beats_checked, good_frames, cksum_fails, oversize_frames, epochs_published);
		if (pending != 0)
			$display("%0d predicted result beats never arrived", pending);
		if (mismatches == 0 && pending == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
